[rtl/core/display_reply_deframer_defines.svh]
// ----------------------------------------------------------------------------
// Display reply deframer assertion macros
// Shared assertion wrappers for the deframer checker. They sample on clk
// and stay quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_REPLY_DEFRAMER_DEFINES_SVH
`define DISPLAY_REPLY_DEFRAMER_DEFINES_SVH

// Clocked property, disabled during reset.
`define DRD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A stalled request keeps valid high and its payload unchanged.
`define DRD_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
	`DRD_ASSERT(lbl, ((vld) && !(rdy)) |=> ((vld) && $stable(sig)), msg)

`endif

[rtl/core/ddf_pkg.sv]
// ----------------------------------------------------------------------------
// Display reply deframer package
// Sizes, frame constants, register codes and the structs that pass
// between the deframer modules.
// ----------------------------------------------------------------------------
package ddf_pkg;

	// Button table
	localparam int unsigned TABLE_ENTRIES = 32;
	localparam int unsigned TBL_IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// Field widths
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ID_W   = 16;
	localparam int unsigned CNT_W  = 5;
	localparam int unsigned WIN_W  = 32;
	localparam int unsigned CAP_W  = 24;

	// Frame format
	localparam logic [BYTE_W-1:0] HEAD_BYTE = 8'hEE;
	localparam logic [WIN_W-1:0]  TAIL_WORD = 32'hFFFC_FFFF;
	localparam logic [CNT_W-1:0]  TAIL_LEN  = 5'd4;
	localparam logic [CNT_W-1:0]  REPLY_MIN = 5'd9;   // five data bytes plus the tail
	localparam logic [CNT_W-1:0]  CAP_FIRST = 5'd2;   // body bytes 2..4 carry id and state
	localparam logic [CNT_W-1:0]  CAP_LAST  = 5'd4;
	localparam logic [CNT_W-1:0]  COUNT_MAX = 5'd31;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_BUTTON_WIDGET = 2'd0,
		REG_READ_SUBCMD   = 2'd1,
		REG_PRESSED       = 2'd2,
		REG_RELEASED      = 2'd3
	} cfg_reg_t;

	localparam logic [BYTE_W-1:0] RST_BUTTON_WIDGET = 8'd177;
	localparam logic [BYTE_W-1:0] RST_READ_SUBCMD   = 8'd17;
	localparam logic [BYTE_W-1:0] RST_PRESSED       = 8'd1;
	localparam logic [BYTE_W-1:0] RST_RELEASED      = 8'd0;

	typedef struct packed {
		logic [BYTE_W-1:0] button_widget;
		logic [BYTE_W-1:0] read_subcmd;
		logic [BYTE_W-1:0] pressed;
		logic [BYTE_W-1:0] released;
	} cfg_t;

	// Table write from the parser
	typedef struct packed {
		logic                 en;
		logic [TBL_IDX_W-1:0] idx;
		logic [BYTE_W-1:0]    state;
	} tbl_wr_t;

	// Table lookup result
	typedef struct packed {
		logic [BYTE_W-1:0] state;
		logic              pressed;
		logic              in_range;
	} tbl_rd_t;

endpackage

[rtl/core/ddf_channels.sv]
// ----------------------------------------------------------------------------
// Display reply deframer channels
// Valid/ready channels for requests into the deframer and results out of it.
// ----------------------------------------------------------------------------
interface ddf_req_if;
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [ddf_pkg::BYTE_W-1:0] rx_byte;
	logic [ddf_pkg::ID_W-1:0]   lookup_id;

	modport source (output valid, req_type, rx_byte, lookup_id, input ready);
	modport sink   (input valid, req_type, rx_byte, lookup_id, output ready);
endinterface

interface ddf_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       frame_done;
	logic                       table_updated;
	logic [ddf_pkg::BYTE_W-1:0] read_state;
	logic                       read_pressed;
	logic                       read_in_range;

	modport source (output valid, frame_done, table_updated, read_state, read_pressed,
		read_in_range, input ready);
	modport sink   (input valid, frame_done, table_updated, read_state, read_pressed,
		read_in_range, output ready);
endinterface

[rtl/core/display_reply_deframer.sv]
// ----------------------------------------------------------------------------
// Display reply deframer
// Parses display reply frames from a byte stream and answers button
// state lookups from the table the replies fill.
// ----------------------------------------------------------------------------
// Usage:
//   req  - request channel. req_type 0 feeds one received byte (rx_byte);
//          req_type 1 looks up the button state of lookup_id.
//   rsp  - one result per request, in request order. Byte requests report
//          frame_done/table_updated; lookups report read_state,
//          read_pressed and read_in_range.
//   cfg  - write port for the four code registers (cfg_wr_en, cfg_index,
//          cfg_data); write only while no request is in flight.
// Path: an accepted request waits in the input register, then moves to the
//   result register once that register is free or draining.
// Throughput: one request per cycle while rsp is not held off; the parser
//   state and the table update in the same cycle as the result is computed, so
//   back-to-back bytes and lookups see each other in order.
// Reset: the parser returns to hunting for the head byte, all table entries
//   read as released and the code registers take their default values.
// Stall: while rsp is held off the result register holds; the input register
//   still fills, and req.ready drops only when both are full.
// ----------------------------------------------------------------------------
module display_reply_deframer (
	input  logic                       clk,
	input  logic                       arst_n,
	ddf_req_if.sink                    req,
	ddf_rsp_if.source                  rsp,
	input  logic                       cfg_wr_en,
	input  logic [1:0]                 cfg_index,
	input  logic [ddf_pkg::BYTE_W-1:0] cfg_data
);

	// Configuration registers
	ddf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.button_widget <= ddf_pkg::RST_BUTTON_WIDGET;
			cfg_q.read_subcmd   <= ddf_pkg::RST_READ_SUBCMD;
			cfg_q.pressed       <= ddf_pkg::RST_PRESSED;
			cfg_q.released      <= ddf_pkg::RST_RELEASED;
		end else if (cfg_wr_en) begin
			case (ddf_pkg::cfg_reg_t'(cfg_index))
				ddf_pkg::REG_BUTTON_WIDGET: cfg_q.button_widget <= cfg_data;
				ddf_pkg::REG_READ_SUBCMD:   cfg_q.read_subcmd   <= cfg_data;
				ddf_pkg::REG_PRESSED:       cfg_q.pressed       <= cfg_data;
				ddf_pkg::REG_RELEASED:      cfg_q.released      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register
	logic                       valid_s1;
	logic                       req_type_s1;
	logic [ddf_pkg::BYTE_W-1:0] rx_byte_s1;
	logic [ddf_pkg::ID_W-1:0]   lookup_id_s1;
	logic                       accept;
	logic                       advance;

	// Result register
	logic                       rsp_valid_q;
	logic                       frame_done_q;
	logic                       table_updated_q;
	logic [ddf_pkg::BYTE_W-1:0] read_state_q;
	logic                       read_pressed_q;
	logic                       read_in_range_q;

	// Move the held request into the result register when it is free or drains now.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1  <= req.req_type;
			rx_byte_s1   <= req.rx_byte;
			lookup_id_s1 <= req.lookup_id;
		end
	end

	// Parser and table work on the held request in the cycle it advances
	logic                 frame_done;
	ddf_pkg::tbl_wr_t     tbl_wr;
	ddf_pkg::tbl_rd_t     tbl_rd;

	ddf_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_en    (advance && !req_type_s1),
		.rx_byte    (rx_byte_s1),
		.cfg        (cfg_q),
		.frame_done (frame_done),
		.tbl_wr     (tbl_wr)
	);

	ddf_btn_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.tbl_wr  (tbl_wr),
		.read_id (lookup_id_s1),
		.cfg     (cfg_q),
		.tbl_rd  (tbl_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Byte requests report framing only; lookups report the table only.
	always_ff @(posedge clk) begin
		if (advance) begin
			if (req_type_s1) begin
				frame_done_q    <= 1'b0;
				table_updated_q <= 1'b0;
				read_state_q    <= tbl_rd.state;
				read_pressed_q  <= tbl_rd.pressed;
				read_in_range_q <= tbl_rd.in_range;
			end else begin
				frame_done_q    <= frame_done;
				table_updated_q <= tbl_wr.en;
				read_state_q    <= '0;
				read_pressed_q  <= 1'b0;
				read_in_range_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.frame_done    = frame_done_q;
	assign rsp.table_updated = table_updated_q;
	assign rsp.read_state    = read_state_q;
	assign rsp.read_pressed  = read_pressed_q;
	assign rsp.read_in_range = read_in_range_q;

endmodule

[rtl/core/ddf_parser.sv]
// ----------------------------------------------------------------------------
// Display reply frame parser
// Tracks head, widget, subcommand and body bytes, spots the tail and
// raises a table write for a finished button read reply.
// ----------------------------------------------------------------------------
module ddf_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       byte_en,
	input  logic [ddf_pkg::BYTE_W-1:0] rx_byte,
	input  ddf_pkg::cfg_t              cfg,
	output logic                       frame_done,
	output ddf_pkg::tbl_wr_t           tbl_wr
);

	typedef enum logic [1:0] {
		PH_HUNT   = 2'd0,
		PH_WIDGET = 2'd1,
		PH_SUBCMD = 2'd2,
		PH_BODY   = 2'd3
	} phase_t;

	phase_t                      phase_q, phase_d;
	logic [ddf_pkg::BYTE_W-1:0]  widget_q, widget_d;
	logic [ddf_pkg::BYTE_W-1:0]  subcmd_q, subcmd_d;
	logic [ddf_pkg::WIN_W-1:0]   win_q, win_d;
	logic [ddf_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic [ddf_pkg::CAP_W-1:0]   cap_q, cap_d;
	logic [ddf_pkg::ID_W-1:0]    reply_id;
	logic                        reply_match;

	assign reply_id = cap_d[ddf_pkg::CAP_W-1:ddf_pkg::BYTE_W];
	assign reply_match = (widget_q == cfg.button_widget) && (subcmd_q == cfg.read_subcmd)
		&& (cnt_d >= ddf_pkg::REPLY_MIN);

	always_comb begin
		phase_d    = phase_q;
		widget_d   = widget_q;
		subcmd_d   = subcmd_q;
		win_d      = win_q;
		cnt_d      = cnt_q;
		cap_d      = cap_q;
		frame_done = 1'b0;
		tbl_wr     = '0;
		if (byte_en) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == ddf_pkg::HEAD_BYTE) begin
						phase_d = PH_WIDGET;
						win_d   = '0;
						cnt_d   = '0;
						cap_d   = '0;
					end
				end
				PH_WIDGET: begin
					widget_d = rx_byte;
					phase_d  = PH_SUBCMD;
				end
				PH_SUBCMD: begin
					subcmd_d = rx_byte;
					phase_d  = PH_BODY;
				end
				PH_BODY: begin
					if (cnt_q inside {[ddf_pkg::CAP_FIRST:ddf_pkg::CAP_LAST]}) begin
						cap_d = {cap_q[ddf_pkg::CAP_W-ddf_pkg::BYTE_W-1:0], rx_byte};
					end
					if (cnt_q < ddf_pkg::COUNT_MAX) begin
						cnt_d = cnt_q + 1'b1;
					end
					win_d = {win_q[ddf_pkg::WIN_W-ddf_pkg::BYTE_W-1:0], rx_byte};
					// first tail after the subcommand closes the frame
					if ((cnt_d >= ddf_pkg::TAIL_LEN) && (win_d == ddf_pkg::TAIL_WORD)) begin
						frame_done = 1'b1;
						phase_d    = PH_HUNT;
						if (reply_match &&
							(reply_id < ddf_pkg::ID_W'(ddf_pkg::TABLE_ENTRIES))) begin
							tbl_wr.en    = 1'b1;
							tbl_wr.idx   = reply_id[ddf_pkg::TBL_IDX_W-1:0];
							tbl_wr.state = cap_d[ddf_pkg::BYTE_W-1:0];
						end
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			widget_q <= '0;
			subcmd_q <= '0;
			win_q    <= '0;
			cnt_q    <= '0;
			cap_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			widget_q <= widget_d;
			subcmd_q <= subcmd_d;
			win_q    <= win_d;
			cnt_q    <= cnt_d;
			cap_q    <= cap_d;
		end
	end

endmodule

[rtl/core/ddf_btn_table.sv]
// ----------------------------------------------------------------------------
// Display reply button table
// Stores button state bytes by control id with a written flag per entry;
// unwritten or out of range ids read as the released code.
// ----------------------------------------------------------------------------
module ddf_btn_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ddf_pkg::tbl_wr_t          tbl_wr,
	input  logic [ddf_pkg::ID_W-1:0]  read_id,
	input  ddf_pkg::cfg_t             cfg,
	output ddf_pkg::tbl_rd_t          tbl_rd
);

	logic [ddf_pkg::BYTE_W-1:0]        state_q [ddf_pkg::TABLE_ENTRIES];
	logic [ddf_pkg::TABLE_ENTRIES-1:0] written_q;
	logic [ddf_pkg::TBL_IDX_W-1:0]     rd_idx;
	logic                              in_range;
	logic [ddf_pkg::BYTE_W-1:0]        rd_state;

	assign in_range = read_id < ddf_pkg::ID_W'(ddf_pkg::TABLE_ENTRIES);
	assign rd_idx   = read_id[ddf_pkg::TBL_IDX_W-1:0];
	assign rd_state = (in_range && written_q[rd_idx]) ? state_q[rd_idx] : cfg.released;

	assign tbl_rd.state    = rd_state;
	assign tbl_rd.in_range = in_range;
	assign tbl_rd.pressed  = in_range && (rd_state == cfg.pressed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (tbl_wr.en) begin
			written_q[tbl_wr.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_wr.en) begin
			state_q[tbl_wr.idx] <= tbl_wr.state;
		end
	end

endmodule

[rtl/core/ddf_checker.sv]
// ----------------------------------------------------------------------------
// Display reply deframer checker
// Port level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "display_reply_deframer_defines.svh"

module ddf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       frame_done,
	input logic                       table_updated,
	input logic [ddf_pkg::BYTE_W-1:0] read_state,
	input logic                       read_pressed,
	input logic                       read_in_range
);

	logic [ddf_pkg::BYTE_W+3:0] rsp_word;

	assign rsp_word = {frame_done, table_updated, read_state, read_pressed, read_in_range};

	`DRD_ASSERT_HOLD(a_rsp_hold, rsp_valid, rsp_ready, rsp_word, "result changed while stalled")

	`DRD_ASSERT(a_update_in_frame, (rsp_valid && table_updated) |-> frame_done, "table update without frame end")

	`DRD_ASSERT(a_pressed_in_range, (rsp_valid && read_pressed) |-> read_in_range, "pressed reported for out of range id")

	`DRD_ASSERT(a_frame_no_read, (rsp_valid && frame_done) |-> (!read_in_range && !read_pressed && (read_state == '0)), "lookup fields set on a frame result")

endmodule

bind display_reply_deframer ddf_checker u_ddf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.frame_done    (rsp.frame_done),
	.table_updated (rsp.table_updated),
	.read_state    (rsp.read_state),
	.read_pressed  (rsp.read_pressed),
	.read_in_range (rsp.read_in_range)
);

[test/display_reply_deframer_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Display reply deframer checker
// Watches the request, result and register ports, predicts each result from
// its own copy of the parser state and button table, and compares in order.
// ----------------------------------------------------------------------------
module display_reply_deframer_check (
	input  logic                       clk,
	input  logic                       arst_n,
	ddf_req_if                         req,
	ddf_rsp_if                         rsp,
	input  logic                       cfg_wr_en,
	input  logic [1:0]                 cfg_index,
	input  logic [ddf_pkg::BYTE_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         outstanding,
	output int                         frames_closed,
	output int                         entries_stored
);
	import ddf_pkg::*;

	typedef enum logic [1:0] {
		SEEK_HEAD   = 2'd0,
		TAKE_WIDGET = 2'd1,
		TAKE_SUBCMD = 2'd2,
		IN_BODY     = 2'd3
	} parse_phase_t;

	typedef struct packed {
		logic              frame_done;
		logic              table_updated;
		logic [BYTE_W-1:0] read_state;
		logic              read_pressed;
		logic              read_in_range;
	} reply_t;

	cfg_t              codes;
	parse_phase_t      phase;
	logic [BYTE_W-1:0] widget;
	logic [BYTE_W-1:0] subcmd;
	logic [WIN_W-1:0]  window;
	logic [CNT_W-1:0]  body_len;
	logic [CAP_W-1:0]  capture;
	logic [BYTE_W-1:0] button_state [TABLE_ENTRIES];
	bit                button_known [TABLE_ENTRIES];
	reply_t            replies_due[$];
	int                mismatches;
	int                awaiting;
	int                frames;
	int                stores;

	assign fail_count     = mismatches;
	assign outstanding    = awaiting;
	assign frames_closed  = frames;
	assign entries_stored = stores;

	task automatic report(string what);
		mismatches++;
		if (mismatches <= 50) begin
			$display("%0t ns: mismatch: %s", $time, what);
		end
	endtask

	// Advance the parser (or look up the table) for one request.
	function automatic reply_t next_reply(logic kind, logic [BYTE_W-1:0] b,
			logic [ID_W-1:0] id);
		reply_t          r;
		logic [ID_W-1:0] reply_id;
		r = '0;
		if (kind) begin
			r.read_state = codes.released;
			if (id < TABLE_ENTRIES) begin
				if (button_known[id[TBL_IDX_W-1:0]]) begin
					r.read_state = button_state[id[TBL_IDX_W-1:0]];
				end
				r.read_pressed  = (r.read_state == codes.pressed);
				r.read_in_range = 1'b1;
			end
			return r;
		end
		case (phase)
		SEEK_HEAD: begin
			if (b == HEAD_BYTE) begin
				phase    = TAKE_WIDGET;
				window   = '0;
				body_len = '0;
				capture  = '0;
			end
		end
		TAKE_WIDGET: begin
			widget = b;
			phase  = TAKE_SUBCMD;
		end
		TAKE_SUBCMD: begin
			subcmd = b;
			phase  = IN_BODY;
		end
		default: begin
			if (body_len >= CAP_FIRST && body_len <= CAP_LAST) begin
				capture = {capture[CAP_W-BYTE_W-1:0], b};
			end
			if (body_len < COUNT_MAX) begin
				body_len++;
			end
			window = {window[WIN_W-BYTE_W-1:0], b};
			if (body_len >= TAIL_LEN && window == TAIL_WORD) begin
				r.frame_done = 1'b1;
				reply_id = capture[CAP_W-1:BYTE_W];
				if (widget == codes.button_widget && subcmd == codes.read_subcmd &&
						body_len >= REPLY_MIN && reply_id < TABLE_ENTRIES) begin
					button_state[reply_id[TBL_IDX_W-1:0]] = capture[BYTE_W-1:0];
					button_known[reply_id[TBL_IDX_W-1:0]] = 1'b1;
					r.table_updated = 1'b1;
				end
				phase = SEEK_HEAD;
			end
		end
		endcase
		return r;
	endfunction

	task automatic compare_reply(reply_t got, reply_t want);
		if (got.frame_done !== want.frame_done) begin
			report($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
		end
		if (got.table_updated !== want.table_updated) begin
			report($sformatf("table_updated %b, want %b", got.table_updated,
				want.table_updated));
		end
		if (got.read_state !== want.read_state) begin
			report($sformatf("read_state %h, want %h", got.read_state, want.read_state));
		end
		if (got.read_pressed !== want.read_pressed) begin
			report($sformatf("read_pressed %b, want %b", got.read_pressed,
				want.read_pressed));
		end
		if (got.read_in_range !== want.read_in_range) begin
			report($sformatf("read_in_range %b, want %b", got.read_in_range,
				want.read_in_range));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			codes    = {RST_BUTTON_WIDGET, RST_READ_SUBCMD, RST_PRESSED, RST_RELEASED};
			phase    = SEEK_HEAD;
			widget   = '0;
			subcmd   = '0;
			window   = '0;
			body_len = '0;
			capture  = '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				button_known[i] = 1'b0;
			end
			replies_due.delete();
			awaiting = 0;
		end else begin
			// Results leaving now belong to requests taken on earlier edges.
			if (rsp.valid && rsp.ready) begin
				got = {rsp.frame_done, rsp.table_updated, rsp.read_state,
					rsp.read_pressed, rsp.read_in_range};
				if (replies_due.size() == 0) begin
					report("result with no request waiting");
				end else begin
					compare_reply(got, replies_due.pop_front());
				end
			end
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
				REG_BUTTON_WIDGET: codes.button_widget = cfg_data;
				REG_READ_SUBCMD:   codes.read_subcmd   = cfg_data;
				REG_PRESSED:       codes.pressed       = cfg_data;
				default:           codes.released      = cfg_data;
				endcase
			end
			if (req.valid && req.ready) begin
				want = next_reply(req.req_type, req.rx_byte, req.lookup_id);
				if (want.frame_done) begin
					frames++;
				end
				if (want.table_updated) begin
					stores++;
				end
				replies_due.push_back(want);
			end
			awaiting = replies_due.size();
		end
	end

endmodule

[test/display_reply_deframer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Display reply deframer testbench
// Feeds byte streams of button replies, short and long frames, broken frames
// and noise, mixed with button lookups, under several register settings.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module display_reply_deframer_test;
	import ddf_pkg::*;

	localparam int STALL_LIMIT     = 1000;  // cycles with no request or result moving
	localparam int SETTLE          = 4;     // two-stage latency plus margin
	localparam int ITEMS_PER_PHASE = 230;
	localparam int SETTINGS        = 5;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [1:0]        cfg_index;
	logic [BYTE_W-1:0] cfg_data;

	bit   steady;   // high: neither side idles
	cfg_t codes;    // register values the stimulus builds frames against
	int   sent;     // requests accepted
	int   ignored;  // line-noise bytes sent, none of them a head byte
	int   fail_count;
	int   outstanding;
	int   frames_closed;
	int   entries_stored;

	ddf_req_if req ();
	ddf_rsp_if rsp ();

	display_reply_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	display_reply_deframer_check reply_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.frames_closed  (frames_closed),
		.entries_stored (entries_stored)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side: hold ready low about a third of the time unless steady.
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= steady || ($urandom_range(99) >= 33);
		end
	end

	// Watchdog: end the run once nothing has moved on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("watchdog: no traffic for %0d cycles, %0d results still due",
			STALL_LIMIT, outstanding);
		$display("TB_ERROR");
		$finish;
	end

	// Offer one request and hold it until the block takes it. Unless steady, a random
	// gap before it sometimes drops valid; back-to-back requests keep valid high.
	task automatic send_req(logic kind, logic [BYTE_W-1:0] b, logic [ID_W-1:0] id);
		if (!steady && $urandom_range(99) < 33) begin
			req.valid   <= 1'b0;
			req.rx_byte <= BYTE_W'($urandom);
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.req_type  <= kind;
		req.rx_byte   <= b;
		req.lookup_id <= id;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent++;
	endtask

	// Unused payload fields carry random values so every bit toggles.
	task automatic send_byte(logic [BYTE_W-1:0] b);
		send_req(1'b0, b, ID_W'($urandom));
	endtask

	task automatic send_read(logic [ID_W-1:0] id);
		send_req(1'b1, BYTE_W'($urandom), id);
	endtask

	task automatic send_frame(logic [BYTE_W-1:0] w, logic [BYTE_W-1:0] s,
			logic [BYTE_W-1:0] body[$]);
		send_byte(HEAD_BYTE);
		send_byte(w);
		send_byte(s);
		foreach (body[i]) begin
			send_byte(body[i]);
		end
		send_byte(TAIL_WORD[31:24]);
		send_byte(TAIL_WORD[23:16]);
		send_byte(TAIL_WORD[15:8]);
		send_byte(TAIL_WORD[7:0]);
	endtask

	// Mostly ids within the table or up to four past its end, now and then any 16-bit id.
	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(9) < 8) begin
			return ID_W'($urandom_range(0, TABLE_ENTRIES + 3));
		end
		return ID_W'($urandom);
	endfunction

	// Build a frame: mostly button replies of the current codes with random
	// content, some too short, some long, with stray head bytes and partial tails.
	task automatic random_frame();
		logic [BYTE_W-1:0] body[$];
		logic [BYTE_W-1:0] w;
		logic [BYTE_W-1:0] s;
		logic [ID_W-1:0]   id;
		int                pick;
		int                n;
		pick = $urandom_range(99);
		if (pick < 70) begin
			n = $urandom_range(5, 8);
		end else if (pick < 85) begin
			n = $urandom_range(0, 4);
		end else begin
			n = $urandom_range(9, 40);
		end
		w  = ($urandom_range(9) < 8) ? codes.button_widget : BYTE_W'($urandom);
		s  = ($urandom_range(9) < 8) ? codes.read_subcmd : BYTE_W'($urandom);
		id = pick_id();
		for (int i = 0; i < n; i++) begin
			body.push_back(($urandom_range(15) == 0) ? HEAD_BYTE : 8'($urandom));
		end
		if (n >= 5) begin
			body[2] = id[15:8];
			body[3] = id[7:0];
			case ($urandom_range(2))
			0:       body[4] = codes.pressed;
			1:       body[4] = codes.released;
			default: body[4] = BYTE_W'($urandom);
			endcase
		end
		// Slip in a tail whose last byte is wrong.
		if ($urandom_range(9) == 0) begin
			body.push_back(TAIL_WORD[31:24]);
			body.push_back(TAIL_WORD[23:16]);
			body.push_back(TAIL_WORD[15:8]);
			body.push_back(8'($urandom_range(0, 8'hFE)));
		end
		send_frame(w, s, body);
	endtask

	task automatic random_unit();
		logic [BYTE_W-1:0] b;
		int                pick;
		int                n;
		pick = $urandom_range(99);
		if (pick < 50) begin
			random_frame();
		end else if (pick < 78) begin
			repeat ($urandom_range(1, 3)) send_read(pick_id());
		end else if (pick < 93) begin
			// Line noise between frames: anything but a head byte.
			n = $urandom_range(1, 4);
			repeat (n) begin
				do b = BYTE_W'($urandom); while (b == HEAD_BYTE);
				send_byte(b);
			end
			ignored += n;
		end else begin
			// Frame cut off before its tail; the next frame's bytes land in its body.
			send_byte(HEAD_BYTE);
			send_byte(codes.button_widget);
			send_byte(codes.read_subcmd);
			repeat ($urandom_range(0, 6)) send_byte(BYTE_W'($urandom));
		end
	endtask

	// Drop valid and wait until every result has come back, then let the
	// pipeline settle.
	task automatic drain();
		req.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all four code registers on consecutive edges; hold the enable
	// high across them.
	task automatic load_codes(cfg_t c);
		cfg_reg_t r;
		cfg_wr_en <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			r = cfg_reg_t'(i);
			cfg_index <= r;
			case (r)
			REG_BUTTON_WIDGET: cfg_data <= c.button_widget;
			REG_READ_SUBCMD:   cfg_data <= c.read_subcmd;
			REG_PRESSED:       cfg_data <= c.pressed;
			default:           cfg_data <= c.released;
			endcase
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		codes = c;
	endtask

	initial begin : stimulus
		cfg_t              plan [SETTINGS];
		logic [BYTE_W-1:0] body[$];
		int                target;
		// Hold every input at a known value through reset.
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= REG_BUTTON_WIDGET;
		cfg_data      <= '0;
		req.valid     <= 1'b0;
		req.req_type  <= 1'b0;
		req.rx_byte   <= '0;
		req.lookup_id <= '0;
		steady        <= 1'b0;
		sent    = 0;
		ignored = 0;
		codes   = {RST_BUTTON_WIDGET, RST_READ_SUBCMD, RST_PRESSED, RST_RELEASED};

		// Settings: reset values, all zero (pressed equals released), all ones but
		// released (FE), head byte as the button widget, then random codes.
		plan[0] = codes;
		plan[1] = {8'h00, 8'h00, 8'h00, 8'h00};
		plan[2] = {8'hFF, 8'hFF, 8'hFF, 8'hFE};
		plan[3] = {HEAD_BYTE, 8'($urandom), 8'($urandom), 8'($urandom)};
		plan[4] = $urandom;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: lookups of unwritten and out-of-range ids at both ends of
		// the id field, a button reply for the last entry, its read-back, and a
		// frame with no data bytes whose widget is the head byte.
		send_read('0);
		send_read(ID_W'(TABLE_ENTRIES - 1));
		send_read(ID_W'(TABLE_ENTRIES));
		send_read('1);
		body = '{8'h00, 8'hFF, 8'h00, 8'(TABLE_ENTRIES - 1), codes.pressed};
		send_frame(codes.button_widget, codes.read_subcmd, body);
		send_read(ID_W'(TABLE_ENTRIES - 1));
		body.delete();
		send_frame(HEAD_BYTE, 8'hFF, body);

		for (int p = 0; p < SETTINGS; p++) begin
			if (p > 0) begin
				// Registers change only with nothing in flight.
				drain();
				load_codes(plan[p]);
			end
			// The all-ones setting runs with no idling on either side.
			steady <= (p == 2);
			target = sent - ignored + ITEMS_PER_PHASE;
			while (sent - ignored < target) random_unit();
		end

		drain();
		$display("Covered %0d requests (%0d noise bytes) under %0d register settings.",
			sent, ignored, SETTINGS);
		$display("Block closed %0d frames and stored %0d button states.",
			frames_closed, entries_stored);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
